// File: rtl/lrast_pkg.sv
// Shared constants, codes and types for the midpoint line rasterizer.
// No dependencies; compiled first.
package lrast_pkg;

    localparam int COORD_BITS_DEF  = 16;
    localparam int QUEUE_DEPTH_DEF = 2;
    localparam int IO_COORD_W      = 16;
    localparam int COLOR_W         = 32;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // Width of one queued command: four flags, five coordinates, the color.
    function automatic int cmd_w(input int coord_bits);
        return 5 * coord_bits + 4 + COLOR_W;
    endfunction

endpackage

// File: rtl/lrast_if.sv
// Valid/ready channel interfaces: line commands in, pixels out.
// Depends on lrast_pkg.
interface lrast_cmd_if;
    import lrast_pkg::*;
    logic                          valid;
    logic                          ready;
    logic                          op;
    logic signed [IO_COORD_W-1:0]  start_x;
    logic signed [IO_COORD_W-1:0]  start_y;
    logic signed [IO_COORD_W-1:0]  end_x;
    logic signed [IO_COORD_W-1:0]  end_y;
    logic        [COLOR_W-1:0]     line_color;

    modport source (output valid, op, start_x, start_y, end_x, end_y, line_color,
                    input ready);
    modport sink   (input valid, op, start_x, start_y, end_x, end_y, line_color,
                    output ready);
endinterface

interface lrast_pix_if;
    import lrast_pkg::*;
    logic                          valid;
    logic                          ready;
    logic signed [IO_COORD_W-1:0]  pixel_x;
    logic signed [IO_COORD_W-1:0]  pixel_y;
    logic        [COLOR_W-1:0]     pixel_color;
    logic                          last;

    modport source (output valid, pixel_x, pixel_y, pixel_color, last, input ready);
    modport sink   (input valid, pixel_x, pixel_y, pixel_color, last, output ready);
endinterface

// File: rtl/lrast_front.sv
// Front end: takes command transfers, picks the major axis and deltas for loads.
// Depends on lrast_pkg and lrast_cmd_if; feeds lrast_queue.
module lrast_front #(
    parameter int COORD_BITS = lrast_pkg::COORD_BITS_DEF,
    localparam int CMD_W     = lrast_pkg::cmd_w(COORD_BITS)
) (
    lrast_cmd_if.sink            i_cmd,
    input  lrast_pkg::t_q_status i_q_status,
    output logic                 o_push,
    output logic [CMD_W-1:0]     o_cmd
);
    import lrast_pkg::*;

    localparam int DW = COORD_BITS + 1;

    typedef struct packed {
        logic                          is_load;
        logic                          swapped;
        logic                          major_neg;
        logic                          minor_neg;
        logic signed [COORD_BITS-1:0]  a0;
        logic signed [COORD_BITS-1:0]  b0;
        logic signed [COORD_BITS-1:0]  a1;
        logic        [COORD_BITS-1:0]  dmaj;
        logic        [COORD_BITS-1:0]  dmin;
        logic        [COLOR_W-1:0]     color;
    } t_cmd;

    logic signed [COORD_BITS-1:0] x0, y0, x1, y1;
    logic signed [DW-1:0]         dx, dy;
    logic        [COORD_BITS-1:0] adx, ady;
    logic                         swap;
    logic                         x_neg, y_neg;
    t_cmd                         w_cmd;

    assign x0 = COORD_BITS'(i_cmd.start_x);
    assign y0 = COORD_BITS'(i_cmd.start_y);
    assign x1 = COORD_BITS'(i_cmd.end_x);
    assign y1 = COORD_BITS'(i_cmd.end_y);

    assign dx = DW'(x1) - DW'(x0);
    assign dy = DW'(y1) - DW'(y0);

    assign adx = dx[DW-1] ? COORD_BITS'(-dx) : COORD_BITS'(dx);
    assign ady = dy[DW-1] ? COORD_BITS'(-dy) : COORD_BITS'(dy);

    // step is negative unless end is strictly greater than start
    assign x_neg = dx[DW-1] || (dx == '0);
    assign y_neg = dy[DW-1] || (dy == '0);
    assign swap  = ady > adx;

    always_comb begin
        w_cmd.is_load   = (i_cmd.op == OP_LOAD);
        w_cmd.swapped   = swap;
        w_cmd.major_neg = swap ? y_neg : x_neg;
        w_cmd.minor_neg = swap ? x_neg : y_neg;
        w_cmd.a0        = swap ? y0 : x0;
        w_cmd.b0        = swap ? x0 : y0;
        w_cmd.a1        = swap ? y1 : x1;
        w_cmd.dmaj      = swap ? ady : adx;
        w_cmd.dmin      = swap ? adx : ady;
        w_cmd.color     = i_cmd.line_color;
    end

    assign i_cmd.ready = !i_q_status.full;
    assign o_push      = i_cmd.valid && !i_q_status.full;
    assign o_cmd       = w_cmd;

endmodule

// File: rtl/lrast_queue.sv
// Short command queue between the front end and the stepper.
// Depends on lrast_pkg.
module lrast_queue #(
    parameter int W     = lrast_pkg::cmd_w(lrast_pkg::COORD_BITS_DEF),
    parameter int DEPTH = lrast_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic [W-1:0]         i_data,
    input  logic                 i_pop,
    output logic [W-1:0]         o_data,
    output lrast_pkg::t_q_status o_status
);
    import lrast_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [PW-1:0] r_wptr, n_wptr;
    logic [PW-1:0] r_rptr, n_rptr;
    logic [NW-1:0] r_count, n_count;
    logic          do_push, do_pop;

    assign do_push = i_push && (r_count != NW'(DEPTH));
    assign do_pop  = i_pop && (r_count != '0);

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (do_push) begin
            n_wptr = (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (do_pop) begin
            n_rptr = (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    assign o_data         = r_mem[r_rptr];
    assign o_status.full  = (r_count == NW'(DEPTH));
    assign o_status.empty = (r_count == '0);

endmodule

// File: rtl/lrast_back.sv
// Stepper: keeps line state, a pixel per load or active step, drives the pixel register.
// Depends on lrast_pkg and lrast_pix_if; fed by lrast_queue.
module lrast_back #(
    parameter int COORD_BITS = lrast_pkg::COORD_BITS_DEF,
    localparam int CMD_W     = lrast_pkg::cmd_w(COORD_BITS)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [CMD_W-1:0]     i_cmd,
    input  lrast_pkg::t_q_status i_q_status,
    output logic                 o_pop,
    lrast_pix_if.source          o_pix
);
    import lrast_pkg::*;

    localparam int EW = COORD_BITS + 3;

    typedef struct packed {
        logic                          is_load;
        logic                          swapped;
        logic                          major_neg;
        logic                          minor_neg;
        logic signed [COORD_BITS-1:0]  a0;
        logic signed [COORD_BITS-1:0]  b0;
        logic signed [COORD_BITS-1:0]  a1;
        logic        [COORD_BITS-1:0]  dmaj;
        logic        [COORD_BITS-1:0]  dmin;
        logic        [COLOR_W-1:0]     color;
    } t_cmd;

    t_cmd                         cmd;
    logic                         pop, emit, last;
    logic signed [EW-1:0]         inc_s_ld, dmaj2, dmaj1;

    logic                         r_active, n_active;
    logic signed [COORD_BITS-1:0] r_major, n_major;
    logic signed [COORD_BITS-1:0] r_minor, n_minor;
    logic signed [COORD_BITS-1:0] r_end, n_end;
    logic signed [EW-1:0]         r_err, n_err;
    logic signed [EW-1:0]         r_inc_s, n_inc_s;
    logic signed [EW-1:0]         r_inc_d, n_inc_d;
    logic                         r_maj_neg, n_maj_neg;
    logic                         r_min_neg, n_min_neg;
    logic                         r_swap, n_swap;
    logic        [COLOR_W-1:0]    r_color, n_color;

    logic                         r_ovalid, n_ovalid;
    logic signed [IO_COORD_W-1:0] r_px, r_py;
    logic        [COLOR_W-1:0]    r_pcolor;
    logic                         r_plast;

    assign cmd = t_cmd'(i_cmd);
    assign pop = !i_q_status.empty && (!r_ovalid || o_pix.ready);

    assign inc_s_ld = $signed(EW'({cmd.dmin, 1'b0}));
    assign dmaj2    = $signed(EW'({cmd.dmaj, 1'b0}));
    assign dmaj1    = $signed(EW'(cmd.dmaj));

    always_comb begin
        n_active  = r_active;
        n_major   = r_major;
        n_minor   = r_minor;
        n_end     = r_end;
        n_err     = r_err;
        n_inc_s   = r_inc_s;
        n_inc_d   = r_inc_d;
        n_maj_neg = r_maj_neg;
        n_min_neg = r_min_neg;
        n_swap    = r_swap;
        n_color   = r_color;
        emit      = 1'b0;
        if (pop) begin
            if (cmd.is_load) begin
                n_major   = cmd.a0;
                n_minor   = cmd.b0;
                n_end     = cmd.a1;
                n_inc_s   = inc_s_ld;
                n_inc_d   = inc_s_ld - dmaj2;
                n_err     = inc_s_ld - dmaj1;
                n_maj_neg = cmd.major_neg;
                n_min_neg = cmd.minor_neg;
                n_swap    = cmd.swapped;
                n_color   = cmd.color;
                emit      = 1'b1;
            end else if (r_active) begin
                // adding all ones steps back by one
                n_major = r_major + $signed({{(COORD_BITS-1){r_maj_neg}}, 1'b1});
                if (!r_err[EW-1] && (r_err != '0)) begin
                    n_minor = r_minor + $signed({{(COORD_BITS-1){r_min_neg}}, 1'b1});
                    n_err   = r_err + r_inc_d;
                end else begin
                    n_err   = r_err + r_inc_s;
                end
                emit = 1'b1;
            end
        end
        last = (n_major == n_end);
        if (emit) begin
            n_active = !last;
        end
        if (pop) begin
            n_ovalid = emit;
        end else begin
            n_ovalid = r_ovalid && !o_pix.ready;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_active <= n_active;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_major   <= n_major;
        r_minor   <= n_minor;
        r_end     <= n_end;
        r_err     <= n_err;
        r_inc_s   <= n_inc_s;
        r_inc_d   <= n_inc_d;
        r_maj_neg <= n_maj_neg;
        r_min_neg <= n_min_neg;
        r_swap    <= n_swap;
        r_color   <= n_color;
        if (emit) begin
            r_px     <= n_swap ? IO_COORD_W'(n_minor) : IO_COORD_W'(n_major);
            r_py     <= n_swap ? IO_COORD_W'(n_major) : IO_COORD_W'(n_minor);
            r_pcolor <= n_color;
            r_plast  <= last;
        end
    end

    assign o_pop             = pop;
    assign o_pix.valid       = r_ovalid;
    assign o_pix.pixel_x     = r_px;
    assign o_pix.pixel_y     = r_py;
    assign o_pix.pixel_color = r_pcolor;
    assign o_pix.last        = r_plast;

endmodule

// File: rtl/midpoint_line_rasterizer_unit.sv
// Top level of the midpoint line rasterizer: front end, command queue, stepper.
// Depends on lrast_pkg, lrast_if, lrast_front, lrast_queue, lrast_back.
//
//   port     dir  kind           contents
//   i_cmd    in   valid/ready    op, start_x, start_y, end_x, end_y, line_color
//   o_pix    out  valid/ready    pixel_x, pixel_y, pixel_color, last
//
// One command per clock sustained while o_pix is not stalled; a pixel's command passes
// through the front setup into the queue, then the stepper into the pixel register.
// The queue holds QUEUE_DEPTH commands; i_cmd.ready drops only when it is full.
// A stalled o_pix holds the stepper; the front keeps filling the queue meanwhile.
// Synchronous active-low reset empties the queue and clears the line and pixel valid.
module midpoint_line_rasterizer_unit #(
    parameter int COORD_BITS  = lrast_pkg::COORD_BITS_DEF,
    parameter int QUEUE_DEPTH = lrast_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lrast_cmd_if.sink   i_cmd,
    lrast_pix_if.source o_pix
);
    import lrast_pkg::*;

    localparam int CMD_W = cmd_w(COORD_BITS);

    logic             push, pop;
    logic [CMD_W-1:0] push_cmd, pop_cmd;
    t_q_status        q_status;

    lrast_front #(.COORD_BITS(COORD_BITS)) u_front (
        .i_cmd      (i_cmd),
        .i_q_status (q_status),
        .o_push     (push),
        .o_cmd      (push_cmd)
    );

    lrast_queue #(.W(CMD_W), .DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_data   (push_cmd),
        .i_pop    (pop),
        .o_data   (pop_cmd),
        .o_status (q_status)
    );

    lrast_back #(.COORD_BITS(COORD_BITS)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (pop_cmd),
        .i_q_status (q_status),
        .o_pop      (pop),
        .o_pix      (o_pix)
    );

`ifndef SYNTHESIS
    a_q_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_status.full && q_status.empty))
        else $error("queue reports full and empty together");

    a_no_spurious_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_status.empty && !o_pix.valid && !(i_cmd.valid && i_cmd.ready))
        |=> !o_pix.valid)
        else $error("pixel appeared with no queued command");

    a_transfer_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.valid && i_cmd.ready && q_status.empty) |=> !q_status.empty)
        else $error("command transfer lost before the queue");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_status.empty |-> i_cmd.ready)
        else $error("front stalled with an empty queue");
`endif

endmodule

// File: tb/tb_midpoint_line_rasterizer_unit.sv
// Testbench for midpoint_line_rasterizer_unit: directed and random line commands with a scoreboard
// that predicts every pixel. Needs lrast_pkg, lrast_if and the rasterizer RTL.

typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [31:0]        color;
    bit                 last;
} line_pixel_t;

class line_pixel_scoreboard;
    line_pixel_t        pixels_due[$];
    int                 errors;
    bit                 drawing;
    logic signed [15:0] major_pos;
    logic signed [15:0] minor_pos;
    logic signed [15:0] major_end;
    int                 err_term;
    int                 inc_straight;
    int                 inc_diagonal;
    bit                 major_neg;
    bit                 minor_neg;
    bit                 swapped;
    logic [31:0]        color;

    function new();
        errors    = 0;
        drawing   = 0;
        major_pos = '0;
        minor_pos = '0;
        major_end = '0;
        err_term  = 0;
        inc_straight = 0;
        inc_diagonal = 0;
        major_neg = 0;
        minor_neg = 0;
        swapped   = 0;
        color     = '0;
    endfunction

    function int pending();
        return pixels_due.size();
    endfunction

    function int mag(int v);
        return (v < 0) ? -v : v;
    endfunction

    function void queue_pixel();
        line_pixel_t p;
        p.x     = swapped ? minor_pos : major_pos;
        p.y     = swapped ? major_pos : minor_pos;
        p.color = color;
        p.last  = (major_pos == major_end);
        drawing = !p.last;
        pixels_due.push_back(p);
    endfunction

    // Returns 1 when the transfer produces a pixel.
    function bit note_cmd(logic op, logic signed [15:0] sx, logic signed [15:0] sy,
                          logic signed [15:0] ex, logic signed [15:0] ey, logic [31:0] c);
        int x0, y0, x1, y1, a0, b0, a1, b1, dmaj, dmin;
        if (op == lrast_pkg::OP_LOAD) begin
            x0 = int'(sx);
            y0 = int'(sy);
            x1 = int'(ex);
            y1 = int'(ey);
            swapped = mag(y1 - y0) > mag(x1 - x0);
            if (swapped) begin
                a0 = y0; b0 = x0; a1 = y1; b1 = x1;
            end else begin
                a0 = x0; b0 = y0; a1 = x1; b1 = y1;
            end
            dmaj = mag(a1 - a0);
            dmin = mag(b1 - b0);
            major_neg    = !(a1 > a0);
            minor_neg    = !(b1 > b0);
            inc_straight = dmin * 2;
            inc_diagonal = (dmin - dmaj) * 2;
            err_term     = dmin * 2 - dmaj;
            major_pos    = a0[15:0];
            minor_pos    = b0[15:0];
            major_end    = a1[15:0];
            color        = c;
            queue_pixel();
            return 1;
        end
        if (!drawing)
            return 0;
        major_pos = major_pos + (major_neg ? -16'sd1 : 16'sd1);
        if (err_term > 0) begin
            minor_pos = minor_pos + (minor_neg ? -16'sd1 : 16'sd1);
            err_term  = err_term + inc_diagonal;
        end else begin
            err_term  = err_term + inc_straight;
        end
        queue_pixel();
        return 1;
    endfunction

    function void check_pix(logic signed [15:0] x, logic signed [15:0] y, logic [31:0] c,
                            logic l);
        line_pixel_t p;
        if (pixels_due.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("unexpected pixel x=%0d y=%0d color=%h last=%b", x, y, c, l);
            return;
        end
        p = pixels_due.pop_front();
        if (x !== p.x || y !== p.y || c !== p.color || l !== p.last) begin
            errors++;
            if (errors <= 10)
                $display(
                    "pixel mismatch: exp x=%0d y=%0d c=%h l=%b got x=%0d y=%0d c=%h l=%b",
                    p.x, p.y, p.color, p.last, x, y, c, l);
        end
    endfunction
endclass

module tb_midpoint_line_rasterizer_unit;
    logic i_clk;
    logic i_rst_n;
    int   send_idle;
    int   recv_stall;
    int   n_pixels;
    int   base_pixels;

    line_pixel_scoreboard sb = new();

    lrast_cmd_if cmd_ch();
    lrast_pix_if pix_ch();

    midpoint_line_rasterizer_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_pix   (pix_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #4000000;
        $display("tb_midpoint_line_rasterizer_unit: errors");
        $finish;
    end

    initial begin
        pix_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pix_ch.valid && pix_ch.ready)
                sb.check_pix(pix_ch.pixel_x, pix_ch.pixel_y, pix_ch.pixel_color, pix_ch.last);
            pix_ch.ready <= ($urandom_range(0, 99) >= recv_stall);
        end
    end

    task automatic send_cmd(input logic op, input logic signed [15:0] sx,
                            input logic signed [15:0] sy, input logic signed [15:0] ex,
                            input logic signed [15:0] ey, input logic [31:0] c);
        if ($urandom_range(0, 99) < send_idle) begin
            cmd_ch.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < send_idle);
        end
        cmd_ch.valid      <= 1'b1;
        cmd_ch.op         <= op;
        cmd_ch.start_x    <= sx;
        cmd_ch.start_y    <= sy;
        cmd_ch.end_x      <= ex;
        cmd_ch.end_y      <= ey;
        cmd_ch.line_color <= c;
        do @(posedge i_clk); while (!cmd_ch.ready);
        if (sb.note_cmd(op, sx, sy, ex, ey, c))
            n_pixels++;
    endtask

    task automatic draw_line(input int sx, input int sy, input int ex, input int ey,
                             input logic [31:0] c, input int n_steps);
        send_cmd(lrast_pkg::OP_LOAD, 16'(sx), 16'(sy), 16'(ex), 16'(ey), c);
        repeat (n_steps)
            send_cmd(lrast_pkg::OP_STEP, 16'($urandom), 16'($urandom), 16'($urandom),
                     16'($urandom), $urandom);
    endtask

    task automatic wait_pixels_drained();
        cmd_ch.valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    task automatic random_line();
        logic signed [15:0] tmp;
        int sx, sy, ex, ey, dx, dy, span, n, kind, major, r;
        kind = $urandom_range(0, 99);
        tmp = 16'($urandom);
        sx = int'(tmp);
        tmp = 16'($urandom);
        sy = int'(tmp);
        if (kind < 6) begin
            tmp = 16'($urandom);
            ex = int'(tmp);
            tmp = 16'($urandom);
            ey = int'(tmp);
            n = $urandom_range(0, 6);
        end else begin
            span = (kind < 88) ? 12 : 64;
            dx = int'($urandom_range(0, 2 * span)) - span;
            dy = int'($urandom_range(0, 2 * span)) - span;
            ex = sx + dx;
            if (ex > 32767 || ex < -32768)
                ex = sx - dx;
            ey = sy + dy;
            if (ey > 32767 || ey < -32768)
                ey = sy - dy;
            major = (dx < 0) ? -dx : dx;
            if (((dy < 0) ? -dy : dy) > major)
                major = (dy < 0) ? -dy : dy;
            r = $urandom_range(0, 99);
            if (r < 10)
                n = $urandom_range(0, major);
            else if (r < 15)
                n = major + $urandom_range(1, 3);
            else
                n = major;
        end
        draw_line(sx, sy, ex, ey, $urandom, n);
    endtask

    initial begin
        cmd_ch.valid      <= 1'b0;
        cmd_ch.op         <= lrast_pkg::OP_LOAD;
        cmd_ch.start_x    <= '0;
        cmd_ch.start_y    <= '0;
        cmd_ch.end_x      <= '0;
        cmd_ch.end_y      <= '0;
        cmd_ch.line_color <= '0;
        i_rst_n           <= 1'b0;
        send_idle  = 0;
        recv_stall = 0;
        n_pixels   = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed lines: idle step, single point, axis lines, tie, extremes, restart
        send_cmd(lrast_pkg::OP_STEP, 16'h7fff, 16'h8000, 16'hffff, 16'h0000, 32'hffffffff);
        draw_line(0, 0, 0, 0, 32'h00000000, 1);
        draw_line(-3, 5, 2, 5, 32'hffffffff, 6);
        draw_line(10, 10, 10, 8, 32'h00ff00ff, 2);
        draw_line(0, 0, -3, 3, 32'ha5a5a5a5, 3);
        draw_line(-32768, -32768, 32767, 32767, 32'h80000001, 2);
        draw_line(32767, -32768, -32768, 32767, 32'h7ffffffe, 1);
        draw_line(5, 5, 3, 1, 32'h12345678, 4);
        wait_pixels_drained();

        base_pixels = n_pixels;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 49; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 49; end
                default: begin send_idle = 6; recv_stall = 6; end
            endcase
            while (n_pixels < base_pixels + 550 * (phase + 1) / 4) begin
                if ($urandom_range(0, 99) < 85)
                    random_line();
                else
                    send_cmd(1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom),
                             16'($urandom), 16'($urandom), $urandom);
            end
            wait_pixels_drained();
        end

        repeat (8) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb_midpoint_line_rasterizer_unit: clean");
        else
            $display("tb_midpoint_line_rasterizer_unit: errors");
        $finish;
    end
endmodule
